### src/srs_pkg.sv
package srs_pkg;

    // Pixel packed as red, green, blue from high to low byte
    typedef logic [23:0] pixel_t;

    // Origin of an output pixel
    typedef enum logic [1:0] {
        SRC_PASS  = 2'd0,
        SRC_SHIFT = 2'd1,
        SRC_FILL  = 2'd2
    } src_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_PIXELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'b1;

    // Register widths and reset values
    localparam int SHIFT_W = 7;
    localparam int WIDTH_W = 13;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 7'd8;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

    // Control from the top level to every delay cell
    typedef struct packed {
        logic advance;
        logic clear_row;
    } cell_ctrl_t;

    // One result item
    typedef struct packed {
        pixel_t pixel;
        src_t   src;
        logic   row_end;
    } out_item_t;

endpackage

### src/srs_cell.sv
module srs_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srs_pkg::cell_ctrl_t ctrl,
    input  logic               sel,
    input  srs_pkg::pixel_t    pix_in,
    input  logic               flag_in,
    output srs_pkg::pixel_t    pix_q,
    output logic               flag_q,
    output srs_pkg::pixel_t    tap_pix,
    output logic               tap_hit
);
    import srs_pkg::*;

    pixel_t pix_reg;
    logic   flag_reg;
    logic   flag_next;

    // Drop source flags that belong to the previous row
    always_comb
    begin
        if (HEAD)
        begin
            flag_next = flag_in;
        end
        else
        begin
            flag_next = flag_in & ~ctrl.clear_row;
        end
    end

    // Advance the pixel by one column
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            pix_reg <= pix_in;
        end
    end

    // Advance the source flag by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            flag_reg <= flag_next;
        end
    end

    assign pix_q   = pix_reg;
    assign flag_q  = flag_reg;

    // Offer the held pixel when this cell is the selected tap and holds a source flag
    assign tap_hit = sel & flag_reg;
    assign tap_pix = tap_hit ? pix_reg : '0;

endmodule

### src/srs_out_buf.sv
module srs_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srs_pkg::out_item_t   push_item,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srs_pkg::out_item_t   pop_item
);
    import srs_pkg::*;

    out_item_t   ent_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop       = out_valid & out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign can_push  = (count_reg != 2'd2);
    assign pop_item  = ent_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the pushed result until its transfer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/segment_row_shift_unit.sv
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one pixel per clock while the output buffer has room; a two-entry
// output buffer keeps input transfers going while one result waits on out_ready.
// The delay is a row of MAX_SHIFT cells advancing one column per transfer.
// Reset: asynchronous, active low; clears control state, cell source flags
// and the output buffer, and restores shift_pixels to 8 and row_width to 640.
module segment_row_shift_unit #(
    parameter int MAX_SHIFT = 64,
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    input  logic [7:0]                      seg_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      red_out,
    output logic [7:0]                      green_out,
    output logic [7:0]                      blue_out,
    output logic [1:0]                      pixel_source,
    output logic                            row_end
);
    import srs_pkg::*;

    localparam int NW = $clog2(MAX_SHIFT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // Configuration registers
    logic [SHIFT_W-1:0] shift_reg;
    logic [WIDTH_W-1:0] width_reg;

    // Row state
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [NW-1:0] run_reg;
    logic [NW-1:0] run_next;
    logic          in_run_reg;
    logic          in_run_next;
    pixel_t        fill_reg;
    pixel_t        fill_next;
    pixel_t        prior0_reg;
    pixel_t        prior1_reg;

    logic          accept;
    logic          can_push;
    pixel_t        pix;
    logic          object;
    logic [NW-1:0] n_eff;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] col_plus;
    logic          row_start;
    logic          last_col;
    logic          in_run_cur;
    logic [NW-1:0] run_cur;
    logic          fill;
    logic          is_source;
    logic          dly_flag;
    pixel_t        dly_pix;
    logic          tap_flag;
    pixel_t        tap_pix_or;
    out_item_t     res_item;
    out_item_t     pop_item;
    cell_ctrl_t    cell_ctrl;

    pixel_t        cell_pix  [MAX_SHIFT];
    logic          cell_flag [MAX_SHIFT];
    pixel_t        cell_tap  [MAX_SHIFT];
    logic          cell_hit  [MAX_SHIFT];
    logic          cell_sel  [MAX_SHIFT];

    assign accept   = in_valid & in_ready;
    assign in_ready = can_push;
    assign pix      = {red_in, green_in, blue_in};
    assign object   = (seg_value == 8'd0);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SHIFT_PIXELS: shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_ROW_WIDTH:    width_reg <= cfg_data[WIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp shift distance and row width
    always_comb
    begin
        if (32'(shift_reg) > 32'(MAX_SHIFT))
        begin
            n_eff = NW'(MAX_SHIFT);
        end
        else
        begin
            n_eff = NW'(shift_reg);
        end
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
    end

    // Track the object run and its fill value
    always_comb
    begin
        row_start   = (col_reg == '0);
        in_run_cur  = row_start ? 1'b0 : in_run_reg;
        run_cur     = row_start ? '0 : run_reg;
        run_next    = run_cur;
        fill_next   = fill_reg;
        in_run_next = object;
        if (object)
        begin
            if (!in_run_cur)
            begin
                run_next = '0;
                if (col_reg == CW'(0))
                begin
                    fill_next = pix;
                end
                else if (col_reg == CW'(1))
                begin
                    fill_next = prior0_reg;
                end
                else
                begin
                    fill_next = prior1_reg;
                end
            end
            else if (run_cur < NW'(MAX_SHIFT))
            begin
                run_next = run_cur + NW'(1);
            end
        end
        fill      = object & (run_next < n_eff);
        is_source = object & ~fill;
    end

    // Advance the column and flag the last pixel of the row
    always_comb
    begin
        col_plus = WW'(col_reg) + WW'(1);
        last_col = (col_plus >= w_eff);
        col_next = last_col ? '0 : CW'(col_plus);
    end

    // Gather the selected tap across the cells
    always_comb
    begin
        tap_flag   = 1'b0;
        tap_pix_or = '0;
        for (int k = 0; k < MAX_SHIFT; k++)
        begin
            tap_flag   = tap_flag | cell_hit[k];
            tap_pix_or = tap_pix_or | cell_tap[k];
        end
    end

    // Pick the pixel from shift_pixels columns back
    always_comb
    begin
        if (n_eff == '0)
        begin
            dly_flag = is_source;
            dly_pix  = pix;
        end
        else
        begin
            dly_flag = tap_flag & ~row_start;
            dly_pix  = tap_pix_or;
        end
    end

    // Form the result
    always_comb
    begin
        res_item.row_end = last_col;
        if (fill)
        begin
            res_item.pixel = fill_next;
            res_item.src   = SRC_FILL;
        end
        else if (dly_flag)
        begin
            res_item.pixel = dly_pix;
            res_item.src   = SRC_SHIFT;
        end
        else
        begin
            res_item.pixel = pix;
            res_item.src   = SRC_PASS;
        end
    end

    // Update row state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            run_reg    <= '0;
            in_run_reg <= 1'b0;
            fill_reg   <= '0;
            prior0_reg <= '0;
            prior1_reg <= '0;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            run_reg    <= run_next;
            in_run_reg <= in_run_next;
            fill_reg   <= fill_next;
            prior0_reg <= pix;
            prior1_reg <= prior0_reg;
        end
    end

    assign cell_ctrl.advance   = accept;
    assign cell_ctrl.clear_row = row_start;

    // Row of delay cells, one column each
    for (genvar k = 0; k < MAX_SHIFT; k++)
    begin : g_cell
        assign cell_sel[k] = (n_eff == NW'(k + 1));
        if (k == 0)
        begin : g_head
            srs_cell #(
                .HEAD (1'b1)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl),
                .sel     (cell_sel[k]),
                .pix_in  (pix),
                .flag_in (is_source),
                .pix_q   (cell_pix[k]),
                .flag_q  (cell_flag[k]),
                .tap_pix (cell_tap[k]),
                .tap_hit (cell_hit[k])
            );
        end
        else
        begin : g_body
            srs_cell #(
                .HEAD (1'b0)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl),
                .sel     (cell_sel[k]),
                .pix_in  (cell_pix[k-1]),
                .flag_in (cell_flag[k-1]),
                .pix_q   (cell_pix[k]),
                .flag_q  (cell_flag[k]),
                .tap_pix (cell_tap[k]),
                .tap_hit (cell_hit[k])
            );
        end
    end

    // Buffer results toward the output
    srs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (res_item),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pop_item  (pop_item)
    );

    assign red_out      = pop_item.pixel[23:16];
    assign green_out    = pop_item.pixel[15:8];
    assign blue_out     = pop_item.pixel[7:0];
    assign pixel_source = pop_item.src;
    assign row_end      = pop_item.row_end;

endmodule

### src/srs_checker.sv
module srs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_write,
    input logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [7:0]                      red_in,
    input logic [7:0]                      green_in,
    input logic [7:0]                      blue_in,
    input logic [7:0]                      seg_value,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [7:0]                      red_out,
    input logic [7:0]                      green_out,
    input logic [7:0]                      blue_out,
    input logic [1:0]                      pixel_source,
    input logic                            row_end
);
    import srs_pkg::*;

    // A stalled result holds its pixel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("stalled result changed");

    // An input transfer shows a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input transfer produced no result");

    // Input back-pressure only while results wait
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // Only defined source codes leave the block
    a_src_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_source == SRC_PASS || pixel_source == SRC_SHIFT
            || pixel_source == SRC_FILL)
        else $error("undefined pixel source code");

endmodule

bind segment_row_shift_unit srs_checker u_srs_checker (.*);
